// ===== sv/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear probe hash table
// Operation, result and slot codes, port widths, reset values and the
// control group that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package lph_pkg;

   // Defaults for the top-level parameters
   localparam int CAPACITY_DEF   = 64;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 64;

   // Fixed port widths
   localparam int MODE_W     = 2;
   localparam int KEY_ID_W   = 32;
   localparam int KEY_HASH_W = 32;
   localparam int VALUE_W    = 64;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 6;

   // Register file
   localparam int                 CSR_ADDR_W       = 3;
   localparam int                 CSR_DATA_W       = 32;
   localparam logic               CSR_LOAD_LIMIT   = 1'b0;
   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 6'd48;

   // Depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_GET = 2'd0,
      OP_SET = 2'd1,
      OP_DEL = 2'd2,
      OP_BAD = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_OK        = 2'd0,
      RS_NOT_FOUND = 2'd1,
      RS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_LIVE  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
   } head_type;

   function automatic op_type decode_mode(input logic [MODE_W-1:0] mode);
      op_type op;
      case (mode)
         OP_GET:  op = OP_GET;
         OP_SET:  op = OP_SET;
         OP_DEL:  op = OP_DEL;
         default: op = OP_BAD;
      endcase
      return op;
   endfunction

endpackage

// ===== sv/lph_ram.sv =====
// ----------------------------------------------------------------------------
// lph_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lph_front.sv =====
// ----------------------------------------------------------------------------
// lph_front: request intake and classification
// Accepts request transactions, decodes the mode, masks the key and value,
// takes the home slot from the hash and queues the result for the back end.
// ----------------------------------------------------------------------------
module lph_front #(
   parameter int CAPACITY   = lph_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          hold,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lph_pkg::MODE_W-1:0]     req_mode,
   input  logic [lph_pkg::KEY_ID_W-1:0]   req_key_id,
   input  logic [lph_pkg::KEY_HASH_W-1:0] req_key_hash,
   input  logic [lph_pkg::VALUE_W-1:0]    req_value_in,
   input  logic                          q_pop,
   output lph_pkg::head_type              head,
   output logic [KEY_BITS-1:0]           q_key,
   output logic [$clog2(CAPACITY)-1:0]   q_home,
   output logic [VALUE_BITS-1:0]         q_value
);
   import lph_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   op_type                ent_op_ff   [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]   ent_key_ff  [QUEUE_DEPTH];
   logic [ADDR_W-1:0]     ent_home_ff [QUEUE_DEPTH];
   logic [VALUE_BITS-1:0] ent_val_ff  [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;

   assign req_stall = hold || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_op_ff[wr_ptr_ff]   <= decode_mode(req_mode);
         ent_key_ff[wr_ptr_ff]  <= KEY_BITS'(req_key_id);
         ent_home_ff[wr_ptr_ff] <= req_key_hash[ADDR_W-1:0];
         ent_val_ff[wr_ptr_ff]  <= VALUE_BITS'(req_value_in);
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.op    = ent_op_ff[rd_ptr_ff];
   assign q_key      = ent_key_ff[rd_ptr_ff];
   assign q_home     = ent_home_ff[rd_ptr_ff];
   assign q_value    = ent_val_ff[rd_ptr_ff];

endmodule

// ===== sv/lph_back.sv =====
// ----------------------------------------------------------------------------
// lph_back: probe engine and result register
// Clears the slot table after reset, walks the probe sequence one slot per
// cycle, applies the update and holds the response until it is taken.
// ----------------------------------------------------------------------------
module lph_back #(
   parameter int CAPACITY   = lph_pkg::CAPACITY_DEF,
   parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        clearing,
   input  lph_pkg::head_type            head,
   input  logic [KEY_BITS-1:0]         q_key,
   input  logic [$clog2(CAPACITY)-1:0] q_home,
   input  logic [VALUE_BITS-1:0]       q_value,
   output logic                        q_pop,
   input  logic [lph_pkg::LIMIT_W-1:0]  load_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lph_pkg::STATUS_W-1:0] rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]  rsp_value_out,
   output logic                        rsp_new_key
);
   import lph_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int WORD_W = 2 + KEY_BITS + VALUE_BITS;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_PROBE
   } state_type;

   state_type             state_ff, state_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic [ADDR_W-1:0]     cur_ff, cur_in;
   logic [ADDR_W-1:0]     n_ff, n_in;
   logic [ADDR_W-1:0]     tomb_ff, tomb_in;
   logic                  have_tomb_ff, have_tomb_in;
   op_type                op_ff, op_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      used_ff, used_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_new_ff, rsp_new_in;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;
   logic [WORD_W-1:0]     rd_data;

   slot_type              rd_st;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic                  is_empty, is_hit, is_tomb, done;
   logic                  have_t, room, out_free;
   logic [ADDR_W-1:0]     tomb_at;

   lph_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_st  = slot_type'(rd_data[WORD_W-1 -: 2]);
   assign rd_key = rd_data[KEY_BITS+VALUE_BITS-1 -: KEY_BITS];
   assign rd_val = rd_data[VALUE_BITS-1:0];

   assign is_empty = (rd_st == SLOT_EMPTY);
   assign is_hit   = (rd_st == SLOT_LIVE) && (rd_key == key_ff);
   assign is_tomb  = (rd_st != SLOT_EMPTY) && (rd_st != SLOT_LIVE);
   assign done     = is_empty || is_hit || (&n_ff);
   assign have_t   = have_tomb_ff || is_tomb;
   assign tomb_at  = have_tomb_ff ? tomb_ff : cur_ff;
   assign room     = CMP_W'(used_ff) < CMP_W'(load_limit);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      tomb_in       = tomb_ff;
      have_tomb_in  = have_tomb_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      used_in       = used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_new_in    = rsp_new_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      rd_addr       = cur_ff + 1'b1;
      q_pop         = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {SLOT_EMPTY, (WORD_W-2)'(0)};
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            rd_addr = q_home;
            if (head.valid && out_free) begin
               q_pop = 1'b1;
               if (head.op == OP_BAD) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = RS_NOT_FOUND;
                  rsp_value_in  = '0;
                  rsp_new_in    = 1'b0;
               end else begin
                  state_in     = S_PROBE;
                  cur_in       = q_home;
                  n_in         = '0;
                  have_tomb_in = 1'b0;
                  op_in        = head.op;
                  key_in       = q_key;
                  val_in       = q_value;
               end
            end
         end

         S_PROBE: begin
            cur_in = cur_ff + 1'b1;
            n_in   = n_ff + 1'b1;
            if (is_tomb && !have_tomb_ff) begin
               have_tomb_in = 1'b1;
               tomb_in      = cur_ff;
            end
            if (done) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = RS_NOT_FOUND;
               rsp_value_in  = '0;
               rsp_new_in    = 1'b0;
               case (op_ff)
                  OP_GET: begin
                     if (is_hit) begin
                        rsp_status_in = RS_OK;
                        rsp_value_in  = rd_val;
                     end
                  end
                  OP_SET: begin
                     if (is_hit) begin
                        wr_en         = 1'b1;
                        wr_data       = {SLOT_LIVE, key_ff, val_ff};
                        rsp_status_in = RS_OK;
                     end else if (have_t) begin
                        wr_en         = 1'b1;
                        wr_addr       = tomb_at;
                        wr_data       = {SLOT_LIVE, key_ff, val_ff};
                        rsp_status_in = RS_OK;
                        rsp_new_in    = 1'b1;
                     end else if (is_empty && room) begin
                        wr_en         = 1'b1;
                        wr_data       = {SLOT_LIVE, key_ff, val_ff};
                        used_in       = used_ff + 1'b1;
                        rsp_status_in = RS_OK;
                        rsp_new_in    = 1'b1;
                     end else begin
                        rsp_status_in = RS_FULL;
                     end
                  end
                  OP_DEL: begin
                     if (is_hit) begin
                        wr_en         = 1'b1;
                        wr_data       = {SLOT_TOMB, rd_key, rd_val};
                        rsp_status_in = RS_OK;
                     end
                  end
                  default: begin
                     rsp_status_in = RS_NOT_FOUND;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff        <= cur_in;
      n_ff          <= n_in;
      tomb_ff       <= tomb_in;
      have_tomb_ff  <= have_tomb_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_new_ff    <= rsp_new_in;
   end

   assign clearing      = (state_ff == S_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = VALUE_W'(rsp_value_ff);
   assign rsp_new_key   = rsp_new_ff;

endmodule

// ===== sv/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// A transaction probes 1..CAPACITY slots (none for the unused mode), and the
//   probe loop reads one slot per cycle from the slot memory. The back end
//   holds one transaction at a time; further requests wait in the queue.
// Reset: synchronous; afterwards a clearing pass marks every slot empty, with
//   requests stalled and register writes still taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
   parameter int CAPACITY   = lph_pkg::CAPACITY_DEF,   // power of two
   parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
   parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [lph_pkg::MODE_W-1:0]      req_mode,
   input  logic [lph_pkg::KEY_ID_W-1:0]    req_key_id,
   input  logic [lph_pkg::KEY_HASH_W-1:0]  req_key_hash,
   input  logic [lph_pkg::VALUE_W-1:0]     req_value_in,
   // Response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [lph_pkg::STATUS_W-1:0]    rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]     rsp_value_out,
   output logic                           rsp_new_key,
   // Register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lph_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lph_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lph_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                           csr_pready
);
   import lph_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);

   // ------------------------------------------------------------------
   // Register file: one register, load_limit, at byte address 0.
   // The register index comes from paddr[2]; the low byte bits are
   // ignored. Writes land on the access cycle of the transfer.
   // ------------------------------------------------------------------
   logic [LIMIT_W-1:0] load_limit_ff, load_limit_in;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      load_limit_in = load_limit_ff;
      if (csr_write && (csr_paddr[2] == CSR_LOAD_LIMIT)) begin
         load_limit_in = csr_pwdata[LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_limit_ff <= LOAD_LIMIT_RESET;
      end else begin
         load_limit_ff <= load_limit_in;
      end
   end

   // Read back the register; unmapped addresses read as zero
   assign csr_prdata = (csr_paddr[2] == CSR_LOAD_LIMIT) ?
                       CSR_DATA_W'(load_limit_ff) : '0;

   // ------------------------------------------------------------------
   // Front end: take the transaction, decode the mode, mask key and
   // value, pick the home slot, and hold it in a short queue so intake
   // keeps going while the back end probes.
   // ------------------------------------------------------------------
   head_type              head;
   logic [KEY_BITS-1:0]   q_key;
   logic [ADDR_W-1:0]     q_home;
   logic [VALUE_BITS-1:0] q_value;
   logic                  q_pop;
   logic                  clearing;

   lph_front #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .hold         (clearing),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_key_id   (req_key_id),
      .req_key_hash (req_key_hash),
      .req_value_in (req_value_in),
      .q_pop        (q_pop),
      .head         (head),
      .q_key        (q_key),
      .q_home       (q_home),
      .q_value      (q_value)
   );

   // ------------------------------------------------------------------
   // Back end: walk slots from the home slot, one per cycle, stopping at
   // a key match or an empty slot or after a full lap. Remember the
   // first tombstone so a set can reuse it. Commit the slot write in the
   // cycle the walk ends, then hold the response until it is taken.
   // Only one transaction is in the back end at a time.
   // ------------------------------------------------------------------
   lph_back #(
      .CAPACITY   (CAPACITY),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .clearing      (clearing),
      .head          (head),
      .q_key         (q_key),
      .q_home        (q_home),
      .q_value       (q_value),
      .q_pop         (q_pop),
      .load_limit    (load_limit_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_new_key   (rsp_new_key)
   );

endmodule

// ===== sv/lph_checker.sv =====
// ----------------------------------------------------------------------------
// lph_checker: response channel checks for the hash table unit
// Watches the response ports only and is bound to the top level.
// ----------------------------------------------------------------------------
module lph_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [lph_pkg::STATUS_W-1:0]    rsp_status,
   input logic [lph_pkg::VALUE_W-1:0]     rsp_value_out,
   input logic                           rsp_new_key
);
   import lph_pkg::*;

   // A stalled response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_value_out) && $stable(rsp_new_key))
      else $error("stalled response changed");

   // Only ok, not found or full are ever reported
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == RS_OK) || (rsp_status == RS_NOT_FOUND) ||
      (rsp_status == RS_FULL))
      else $error("undefined response status");

   // A failed transaction returns no value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != RS_OK) |-> (rsp_value_out == '0))
      else $error("value returned with failing status");

   // A new key is reported only for a set that succeeded and returns no value
   a_new_key_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_new_key |-> (rsp_status == RS_OK) && (rsp_value_out == '0))
      else $error("new key flagged on failed or get response");

endmodule

bind linear_probe_hash_table_unit lph_checker u_lph_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_value_out (rsp_value_out),
   .rsp_new_key   (rsp_new_key)
);
